// ===== hdl/dual_region_blob_bbox_centroid_core_assert.svh =====
// Assertion macros shared by the blob bounding box design.
`ifndef DUAL_REGION_BLOB_BBOX_CENTROID_CORE_ASSERT_SVH
`define DUAL_REGION_BLOB_BBOX_CENTROID_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DRBB_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DRBB_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/drbb_pkg.sv =====
package drbb_pkg;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 16;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_LEVEL_LOW     = 3'd0,
    CFG_LEVEL_HIGH    = 3'd1,
    CFG_WINDOW_TOP    = 3'd2,
    CFG_WINDOW_BOTTOM = 3'd3,
    CFG_WINDOW_LEFT   = 3'd4,
    CFG_WINDOW_RIGHT  = 3'd5,
    CFG_SPLIT_COLUMN  = 3'd6
  } cfg_index_e;

  // Control for one region's box accumulator.
  typedef struct packed {
    logic adv;    // the pixel stage retires its word this cycle
    logic widen;  // the pixel is a hit for this region
    logic clear;  // the word ends the frame
  } box_ctl_t;

endpackage

// ===== hdl/drbb_box.sv =====
module drbb_box #(
  parameter int COORD_BITS = 11
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  drbb_pkg::box_ctl_t    ctl_i,
  input  logic [COORD_BITS-1:0] row_i,
  input  logic [COORD_BITS-1:0] col_i,
  output logic [COORD_BITS-1:0] row_min_o,
  output logic [COORD_BITS-1:0] row_max_o,
  output logic [COORD_BITS-1:0] col_min_o,
  output logic [COORD_BITS-1:0] col_max_o,
  output logic                  hit_o
);

  logic [COORD_BITS-1:0] row_min_q, row_max_q, col_min_q, col_max_q;
  logic                  hit_q;

  // The box as it stands once the current pixel is folded in.
  always_comb begin
    row_min_o = row_min_q;
    row_max_o = row_max_q;
    col_min_o = col_min_q;
    col_max_o = col_max_q;
    if (ctl_i.widen) begin
      if (row_i < row_min_q) row_min_o = row_i;
      if (row_i > row_max_q) row_max_o = row_i;
      if (col_i < col_min_q) col_min_o = col_i;
      if (col_i > col_max_q) col_max_o = col_i;
    end
    hit_o = hit_q | ctl_i.widen;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_min_q <= '1;
      row_max_q <= '0;
      col_min_q <= '1;
      col_max_q <= '0;
      hit_q     <= 1'b0;
    end else if (ctl_i.adv) begin
      if (ctl_i.clear) begin
        row_min_q <= '1;
        row_max_q <= '0;
        col_min_q <= '1;
        col_max_q <= '0;
        hit_q     <= 1'b0;
      end else begin
        row_min_q <= row_min_o;
        row_max_q <= row_max_o;
        col_min_q <= col_min_o;
        col_max_q <= col_max_o;
        hit_q     <= hit_o;
      end
    end
  end

endmodule

// ===== hdl/dual_region_blob_bbox_centroid_core.sv =====
// A frame-end word is taken into the input register and its first result then into the
// output register; a second result, for the right region, waits in the pending register.
// Throughput: one pixel word per cycle unless stalled; only compares and min/max against
// registers. A frame end with hits in both regions fills both the output and pending
// registers, so a frame-end word with a hit right behind it waits for the pending one to empty.
// Reset: registers take their default values, both boxes are cleared, no word is held.
`include "dual_region_blob_bbox_centroid_core_assert.svh"

module dual_region_blob_bbox_centroid_core #(
  parameter int COORD_BITS = 11,
  parameter int LEVEL_BITS = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [drbb_pkg::CFG_INDEX_BITS-1:0] cfg_index_i,
  input  logic [drbb_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  // pixel stream
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [LEVEL_BITS-1:0]               pixel_level_i,
  input  logic [COORD_BITS-1:0]               pixel_row_i,
  input  logic [COORD_BITS-1:0]               pixel_col_i,
  input  logic                                frame_end_i,
  // results
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                region_side_o,
  output logic [COORD_BITS-1:0]               box_row_min_o,
  output logic [COORD_BITS-1:0]               box_row_max_o,
  output logic [COORD_BITS-1:0]               box_col_min_o,
  output logic [COORD_BITS-1:0]               box_col_max_o,
  output logic [COORD_BITS:0]                 centre_row_twice_o,
  output logic [COORD_BITS:0]                 centre_col_twice_o,
  output logic                                run_last_o
);

  typedef struct packed {
    logic                  side;
    logic [COORD_BITS-1:0] row_min;
    logic [COORD_BITS-1:0] row_max;
    logic [COORD_BITS-1:0] col_min;
    logic [COORD_BITS-1:0] col_max;
    logic [COORD_BITS:0]   crow;
    logic [COORD_BITS:0]   ccol;
    logic                  last;
  } result_t;

  // Configuration registers.
  logic [LEVEL_BITS-1:0] level_low_q, level_high_q;
  logic [COORD_BITS-1:0] win_top_q, win_bottom_q, win_left_q, win_right_q, split_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_low_q  <= LEVEL_BITS'(60);
      level_high_q <= LEVEL_BITS'(75);
      win_top_q    <= COORD_BITS'(50);
      win_bottom_q <= COORD_BITS'(419);
      win_left_q   <= COORD_BITS'(50);
      win_right_q  <= COORD_BITS'(489);
      split_q      <= COORD_BITS'(320);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        drbb_pkg::CFG_LEVEL_LOW:     level_low_q  <= cfg_data_i[LEVEL_BITS-1:0];
        drbb_pkg::CFG_LEVEL_HIGH:    level_high_q <= cfg_data_i[LEVEL_BITS-1:0];
        drbb_pkg::CFG_WINDOW_TOP:    win_top_q    <= cfg_data_i[COORD_BITS-1:0];
        drbb_pkg::CFG_WINDOW_BOTTOM: win_bottom_q <= cfg_data_i[COORD_BITS-1:0];
        drbb_pkg::CFG_WINDOW_LEFT:   win_left_q   <= cfg_data_i[COORD_BITS-1:0];
        drbb_pkg::CFG_WINDOW_RIGHT:  win_right_q  <= cfg_data_i[COORD_BITS-1:0];
        drbb_pkg::CFG_SPLIT_COLUMN:  split_q      <= cfg_data_i[COORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Input register.
  logic                  s1_valid_q;
  logic [LEVEL_BITS-1:0] s1_level_q;
  logic [COORD_BITS-1:0] s1_row_q, s1_col_q;
  logic                  s1_fend_q;
  logic                  s1_adv;

  assign in_stall_o = s1_valid_q && !s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_level_q <= pixel_level_i;
      s1_row_q   <= pixel_row_i;
      s1_col_q   <= pixel_col_i;
      s1_fend_q  <= frame_end_i;
    end
  end

  // Hit classification.
  logic pix_hit, go_left;
  assign pix_hit = s1_valid_q &&
                   (s1_row_q >= win_top_q) && (s1_row_q <= win_bottom_q) &&
                   (s1_col_q >= win_left_q) && (s1_col_q <= win_right_q) &&
                   (s1_level_q >= level_low_q) && (s1_level_q <= level_high_q);
  assign go_left = (s1_col_q <= split_q);

  drbb_pkg::box_ctl_t    left_ctl, right_ctl;
  logic [COORD_BITS-1:0] l_rmin, l_rmax, l_cmin, l_cmax;
  logic [COORD_BITS-1:0] r_rmin, r_rmax, r_cmin, r_cmax;
  logic                  l_hit, r_hit;

  always_comb begin
    left_ctl.adv    = s1_adv;
    left_ctl.widen  = pix_hit && go_left;
    left_ctl.clear  = s1_fend_q;
    right_ctl.adv   = s1_adv;
    right_ctl.widen = pix_hit && !go_left;
    right_ctl.clear = s1_fend_q;
  end

  drbb_box #(.COORD_BITS(COORD_BITS)) u_left (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (left_ctl),
    .row_i     (s1_row_q),
    .col_i     (s1_col_q),
    .row_min_o (l_rmin),
    .row_max_o (l_rmax),
    .col_min_o (l_cmin),
    .col_max_o (l_cmax),
    .hit_o     (l_hit)
  );

  drbb_box #(.COORD_BITS(COORD_BITS)) u_right (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (right_ctl),
    .row_i     (s1_row_q),
    .col_i     (s1_col_q),
    .row_min_o (r_rmin),
    .row_max_o (r_rmax),
    .col_min_o (r_cmin),
    .col_max_o (r_cmax),
    .hit_o     (r_hit)
  );

  // Results of a frame-end word.
  logic    emit_left, emit_right, has_res;
  result_t left_res, right_res;

  assign emit_left  = s1_valid_q && s1_fend_q && l_hit;
  assign emit_right = s1_valid_q && s1_fend_q && r_hit;
  assign has_res    = emit_left || emit_right;

  always_comb begin
    left_res.side     = 1'b0;
    left_res.row_min  = l_rmin;
    left_res.row_max  = l_rmax;
    left_res.col_min  = l_cmin;
    left_res.col_max  = l_cmax;
    left_res.crow     = {1'b0, l_rmin} + {1'b0, l_rmax};
    left_res.ccol     = {1'b0, l_cmin} + {1'b0, l_cmax};
    left_res.last     = !r_hit;
    right_res.side    = 1'b1;
    right_res.row_min = r_rmin;
    right_res.row_max = r_rmax;
    right_res.col_min = r_cmin;
    right_res.col_max = r_cmax;
    right_res.crow    = {1'b0, r_rmin} + {1'b0, r_rmax};
    right_res.ccol    = {1'b0, r_cmin} + {1'b0, r_cmax};
    right_res.last    = 1'b1;
  end

  // Output register plus one pending slot for the right-region result.
  logic    out_valid_q, out_valid_d, pend_valid_q, pend_valid_d;
  result_t out_q, out_d, pend_q, pend_d;
  logic    out_free;

  assign out_free = !out_valid_q || !out_stall_i;
  assign s1_adv   = s1_valid_q && (!has_res || (!pend_valid_q && out_free));

  always_comb begin
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    if (pend_valid_q && out_free) begin
      out_valid_d  = 1'b1;
      out_d        = pend_q;
      pend_valid_d = 1'b0;
    end else if (s1_adv && has_res) begin
      out_valid_d  = 1'b1;
      out_d        = emit_left ? left_res : right_res;
      pend_valid_d = emit_left && emit_right;
      pend_d       = right_res;
    end else if (out_free) begin
      out_valid_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    pend_q <= pend_d;
  end

  assign out_valid_o        = out_valid_q;
  assign region_side_o      = out_q.side;
  assign box_row_min_o      = out_q.row_min;
  assign box_row_max_o      = out_q.row_max;
  assign box_col_min_o      = out_q.col_min;
  assign box_col_max_o      = out_q.col_max;
  assign centre_row_twice_o = out_q.crow;
  assign centre_col_twice_o = out_q.ccol;
  assign run_last_o         = out_q.last;

  `DRBB_ASSERT_IMP(a_pend_needs_out, clk_i, rst_ni, pend_valid_q, out_valid_q,
                   "pending result without output")
  `DRBB_ASSERT_IMP(a_pend_is_right_last, clk_i, rst_ni, pend_valid_q,
                   pend_q.side && pend_q.last, "pending result is not the final right region")
  `DRBB_ASSERT_NXT(a_two_results_pend, clk_i, rst_ni, s1_adv && emit_left && emit_right,
                   pend_valid_q, "second result of a frame was dropped")
  `DRBB_ASSERT_IMP(a_not_last_has_follow, clk_i, rst_ni, out_valid_q && !out_q.last,
                   pend_valid_q, "non-final result without a following one")

endmodule

// ===== sim/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_CYCLES = 6;
  localparam int QUIET_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_PIXELS = 70;

  typedef struct packed {
    logic [10:0] rmin;
    logic [10:0] rmax;
    logic [10:0] cmin;
    logic [10:0] cmax;
  } bbox_t;

  typedef struct packed {
    logic        side;
    logic [10:0] rmin;
    logic [10:0] rmax;
    logic [10:0] cmin;
    logic [10:0] cmax;
    logic [11:0] crow;
    logic [11:0] ccol;
    logic        run_last;
  } box_word_t;

  typedef struct {
    bit                   is_write;
    drbb_pkg::cfg_index_e reg_index;
    logic [15:0]          reg_data;
    logic [7:0]           level;
    logic [10:0]          row;
    logic [10:0]          col;
    logic                 fend;
    int                   typed_n;
    box_word_t            want0;
    box_word_t            want1;
  } stim_row_t;

  localparam bbox_t     CLEARED_BOX = {11'h7FF, 11'h000, 11'h7FF, 11'h000};
  localparam box_word_t NO_BOX      = '0;

  logic                 clk = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  drbb_pkg::cfg_index_e cfg_index = drbb_pkg::CFG_LEVEL_LOW;
  logic [15:0]          cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [7:0]           pixel_level = '0;
  logic [10:0]          pixel_row = '0;
  logic [10:0]          pixel_col = '0;
  logic                 frame_end = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 region_side;
  logic [10:0]          box_row_min;
  logic [10:0]          box_row_max;
  logic [10:0]          box_col_min;
  logic [10:0]          box_col_max;
  logic [11:0]          centre_row_twice;
  logic [11:0]          centre_col_twice;
  logic                 run_last;

  dual_region_blob_bbox_centroid_core dut (
    .clk_i              (clk),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_o        (cfg_ready),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .pixel_level_i      (pixel_level),
    .pixel_row_i        (pixel_row),
    .pixel_col_i        (pixel_col),
    .frame_end_i        (frame_end),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .region_side_o      (region_side),
    .box_row_min_o      (box_row_min),
    .box_row_max_o      (box_row_max),
    .box_col_min_o      (box_col_min),
    .box_col_max_o      (box_col_max),
    .centre_row_twice_o (centre_row_twice),
    .centre_col_twice_o (centre_col_twice),
    .run_last_o         (run_last)
  );

  // Shadow copy of the block's registers and accumulators.
  logic [7:0]  lvl_lo = 8'd60;
  logic [7:0]  lvl_hi = 8'd75;
  logic [10:0] win_top = 11'd50;
  logic [10:0] win_bottom = 11'd419;
  logic [10:0] win_left = 11'd50;
  logic [10:0] win_right = 11'd489;
  logic [10:0] split_col = 11'd320;
  bbox_t       left_acc = CLEARED_BOX;
  bbox_t       right_acc = CLEARED_BOX;
  logic        left_seen = 1'b0;
  logic        right_seen = 1'b0;

  box_word_t   pending_boxes[$];
  stim_row_t   stim_table[$];

  int send_idle_pct = 0;
  int stall_pct = 0;
  bit hold_start = 1'b0;
  int hold_left = 0;
  int errors = 0;
  int pixels_sent = 0;
  int boxes_checked = 0;
  int reg_writes = 0;
  int quiet_cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic bbox_t widen(bbox_t b, logic [10:0] row, logic [10:0] col);
    if (row < b.rmin) b.rmin = row;
    if (row > b.rmax) b.rmax = row;
    if (col < b.cmin) b.cmin = col;
    if (col > b.cmax) b.cmax = col;
    return b;
  endfunction

  function automatic box_word_t to_word(logic side, bbox_t b, logic fin);
    box_word_t w;
    w.side = side;
    w.rmin = b.rmin;
    w.rmax = b.rmax;
    w.cmin = b.cmin;
    w.cmax = b.cmax;
    w.crow = {1'b0, b.rmin} + {1'b0, b.rmax};
    w.ccol = {1'b0, b.cmin} + {1'b0, b.cmax};
    w.run_last = fin;
    return w;
  endfunction

  function automatic box_word_t bw(logic side, int rmin, int rmax, int cmin, int cmax,
                                   int crow, int ccol, logic fin);
    return {side, 11'(rmin), 11'(rmax), 11'(cmin), 11'(cmax), 12'(crow), 12'(ccol), fin};
  endfunction

  function automatic void add_write(drbb_pkg::cfg_index_e idx, logic [15:0] data);
    stim_row_t r;
    r.is_write = 1'b1;
    r.reg_index = idx;
    r.reg_data = data;
    r.level = '0;
    r.row = '0;
    r.col = '0;
    r.fend = 1'b0;
    r.typed_n = 0;
    r.want0 = NO_BOX;
    r.want1 = NO_BOX;
    stim_table.push_back(r);
  endfunction

  function automatic void add_checked(logic [7:0] level, logic [10:0] row, logic [10:0] col,
                                      logic fend, int n, box_word_t w0, box_word_t w1);
    stim_row_t r;
    r.is_write = 1'b0;
    r.reg_index = drbb_pkg::CFG_LEVEL_LOW;
    r.reg_data = '0;
    r.level = level;
    r.row = row;
    r.col = col;
    r.fend = fend;
    r.typed_n = n;
    r.want0 = w0;
    r.want1 = w1;
    stim_table.push_back(r);
  endfunction

  function automatic void add_pixel(logic [7:0] level, logic [10:0] row, logic [10:0] col,
                                    logic fend);
    add_checked(level, row, col, fend, -1, NO_BOX, NO_BOX);
  endfunction

  function automatic bit same(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
    end
    return want == got;
  endfunction

  task automatic predict_boxes(input logic [7:0] level, input logic [10:0] row,
                               input logic [10:0] col, input logic fend,
                               output box_word_t res0, output box_word_t res1,
                               output int n);
    n = 0;
    res0 = NO_BOX;
    res1 = NO_BOX;
    if (row >= win_top && row <= win_bottom && col >= win_left && col <= win_right &&
        level >= lvl_lo && level <= lvl_hi) begin
      if (col <= split_col) begin
        left_acc = widen(left_acc, row, col);
        left_seen = 1'b1;
      end else begin
        right_acc = widen(right_acc, row, col);
        right_seen = 1'b1;
      end
    end
    if (fend) begin
      if (left_seen) begin
        res0 = to_word(1'b0, left_acc, !right_seen);
        n = 1;
      end
      if (right_seen) begin
        if (n == 0) begin
          res0 = to_word(1'b1, right_acc, 1'b1);
        end else begin
          res1 = to_word(1'b1, right_acc, 1'b1);
        end
        n++;
      end
      left_acc = CLEARED_BOX;
      right_acc = CLEARED_BOX;
      left_seen = 1'b0;
      right_seen = 1'b0;
    end
  endtask

  task automatic send_pixel(input logic [7:0] level, input logic [10:0] row,
                            input logic [10:0] col, input logic fend, input int typed_n,
                            input box_word_t want0, input box_word_t want1);
    int gap;
    int n;
    box_word_t got0;
    box_word_t got1;
    gap = 0;
    while (gap < 40 && $urandom_range(0, 99) < send_idle_pct) gap++;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    pixel_level <= level;
    pixel_row <= row;
    pixel_col <= col;
    frame_end <= fend;
    do @(posedge clk); while (in_stall);
    predict_boxes(level, row, col, fend, got0, got1, n);
    if (typed_n < 0) begin
      if (n > 0) pending_boxes.push_back(got0);
      if (n > 1) pending_boxes.push_back(got1);
    end else begin
      if (typed_n > 0) pending_boxes.push_back(want0);
      if (typed_n > 1) pending_boxes.push_back(want1);
    end
    pixels_sent++;
  endtask

  // Stop sending, let every expected box arrive, then give the pipeline time to empty.
  task automatic quiesce();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_boxes.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input drbb_pkg::cfg_index_e idx, input logic [15:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      drbb_pkg::CFG_LEVEL_LOW:     lvl_lo = data[7:0];
      drbb_pkg::CFG_LEVEL_HIGH:    lvl_hi = data[7:0];
      drbb_pkg::CFG_WINDOW_TOP:    win_top = data[10:0];
      drbb_pkg::CFG_WINDOW_BOTTOM: win_bottom = data[10:0];
      drbb_pkg::CFG_WINDOW_LEFT:   win_left = data[10:0];
      drbb_pkg::CFG_WINDOW_RIGHT:  win_right = data[10:0];
      drbb_pkg::CFG_SPLIT_COLUMN:  split_col = data[10:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Writes all registers; unused upper data bits are randomized to exercise masking.
  task automatic apply_setting(input int kind);
    logic [7:0]  lo;
    logic [7:0]  hi;
    logic [10:0] t;
    logic [10:0] b;
    logic [10:0] l;
    logic [10:0] r;
    logic [10:0] s;
    lo = 8'($urandom_range(0, 200));
    hi = lo + 8'($urandom_range(0, 55));
    t = 11'($urandom_range(0, 1800));
    b = t + 11'($urandom_range(0, 2047 - t));
    l = 11'($urandom_range(0, 1800));
    r = l + 11'($urandom_range(0, 2047 - l));
    s = 11'($urandom_range(l, r));
    case (kind)
      1: begin
        lo = 8'd0;
        hi = 8'd255;
        t = 11'd0;
        b = 11'd2047;
        l = 11'd0;
        r = 11'd2047;
      end
      2: s = $urandom_range(0, 1) ? 11'd2047 : 11'd0;
      3: begin
        lo = 8'd60;
        hi = 8'd75;
        t = 11'd50;
        b = 11'd419;
        l = 11'd50;
        r = 11'd489;
        s = 11'd320;
      end
      default: ;
    endcase
    write_reg(drbb_pkg::CFG_LEVEL_LOW, {8'($urandom), lo});
    write_reg(drbb_pkg::CFG_LEVEL_HIGH, {8'($urandom), hi});
    write_reg(drbb_pkg::CFG_WINDOW_TOP, {5'($urandom), t});
    write_reg(drbb_pkg::CFG_WINDOW_BOTTOM, {5'($urandom), b});
    write_reg(drbb_pkg::CFG_WINDOW_LEFT, {5'($urandom), l});
    write_reg(drbb_pkg::CFG_WINDOW_RIGHT, {5'($urandom), r});
    write_reg(drbb_pkg::CFG_SPLIT_COLUMN, {5'($urandom), s});
  endtask

  // Mostly pixels aimed into the window and band, with some fully random noise words
  // that may also cut the frame short.
  task automatic send_frame(input int len);
    logic [7:0]  level;
    logic [10:0] row;
    logic [10:0] col;
    logic        fend;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < 15) begin
        level = 8'($urandom);
        row = 11'($urandom);
        col = 11'($urandom);
        fend = (i == len - 1) || ($urandom_range(0, 7) == 0);
      end else begin
        level = 8'($urandom_range(lvl_lo, lvl_hi));
        row = 11'($urandom_range(win_top, win_bottom));
        col = 11'($urandom_range(win_left, win_right));
        fend = (i == len - 1);
      end
      send_pixel(level, row, col, fend, -1, NO_BOX, NO_BOX);
    end
  endtask

  always @(negedge clk) begin
    if (hold_start) begin
      hold_start = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    out_stall <= (hold_left > 0) || ($urandom_range(0, 99) < stall_pct);
    if (hold_left > 0) hold_left--;
  end

  always @(posedge clk) begin
    box_word_t seen;
    box_word_t want;
    bit ok;
    if (rst_ni && out_valid && !out_stall) begin
      seen = {region_side, box_row_min, box_row_max, box_col_min, box_col_max,
              centre_row_twice, centre_col_twice, run_last};
      if (pending_boxes.size() == 0) begin
        $error("box word arrived with nothing expected");
        errors++;
      end else begin
        want = pending_boxes.pop_front();
        ok = same("region_side", want.side, seen.side);
        ok = same("box_row_min", want.rmin, seen.rmin) & ok;
        ok = same("box_row_max", want.rmax, seen.rmax) & ok;
        ok = same("box_col_min", want.cmin, seen.cmin) & ok;
        ok = same("box_col_max", want.cmax, seen.cmax) & ok;
        ok = same("centre_row_twice", want.crow, seen.crow) & ok;
        ok = same("centre_col_twice", want.ccol, seen.ccol) & ok;
        ok = same("run_last", want.run_last, seen.run_last) & ok;
        if (!ok) errors++;
      end
      boxes_checked++;
    end
  end

  always @(posedge clk) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    stim_row_t step;
    int target;

    // Directed rows under the reset settings: window corners, band edges, misses.
    add_checked(60, 50, 50, 1, 1, bw(0, 50, 50, 50, 50, 100, 100, 1), NO_BOX);
    add_checked(75, 419, 489, 1, 1, bw(1, 419, 419, 489, 489, 838, 978, 1), NO_BOX);
    add_checked(0, 0, 0, 1, 0, NO_BOX, NO_BOX);
    add_pixel(59, 100, 100, 0);
    add_pixel(76, 100, 100, 0);
    add_pixel(70, 49, 100, 0);
    add_pixel(70, 420, 100, 0);
    add_pixel(70, 100, 49, 0);
    add_pixel(70, 100, 490, 0);
    add_checked(255, 2047, 2047, 1, 0, NO_BOX, NO_BOX);
    add_pixel(65, 100, 320, 0);
    add_pixel(65, 200, 321, 0);
    add_checked(70, 150, 60, 1, 2, bw(0, 100, 150, 60, 320, 250, 380, 0),
                bw(1, 200, 200, 321, 321, 400, 642, 1));
    // Full window and band; upper data bits must be dropped.
    add_write(drbb_pkg::CFG_LEVEL_LOW, 16'hFF00);
    add_write(drbb_pkg::CFG_LEVEL_HIGH, 16'h00FF);
    add_write(drbb_pkg::CFG_WINDOW_TOP, 16'hF800);
    add_write(drbb_pkg::CFG_WINDOW_BOTTOM, 16'hF7FF);
    add_write(drbb_pkg::CFG_WINDOW_LEFT, 16'h0000);
    add_write(drbb_pkg::CFG_WINDOW_RIGHT, 16'h07FF);
    add_write(drbb_pkg::CFG_SPLIT_COLUMN, 16'hFFFF);
    add_pixel(255, 2047, 2047, 0);
    add_checked(0, 0, 0, 1, 1, bw(0, 0, 2047, 0, 2047, 2047, 2047, 1), NO_BOX);
    add_write(drbb_pkg::CFG_SPLIT_COLUMN, 16'h0000);
    add_pixel(0, 0, 0, 0);
    add_checked(255, 2047, 1, 1, 2, bw(0, 0, 0, 0, 0, 0, 0, 0),
                bw(1, 2047, 2047, 1, 1, 4094, 2, 1));
    // Empty band, then a window empty in rows, then one empty in columns.
    add_write(drbb_pkg::CFG_LEVEL_LOW, 16'd200);
    add_write(drbb_pkg::CFG_LEVEL_HIGH, 16'd100);
    add_checked(150, 10, 10, 1, 0, NO_BOX, NO_BOX);
    add_write(drbb_pkg::CFG_LEVEL_LOW, 16'd0);
    add_write(drbb_pkg::CFG_LEVEL_HIGH, 16'd255);
    add_write(drbb_pkg::CFG_WINDOW_TOP, 16'd500);
    add_write(drbb_pkg::CFG_WINDOW_BOTTOM, 16'd400);
    add_checked(128, 450, 10, 1, 0, NO_BOX, NO_BOX);
    add_write(drbb_pkg::CFG_WINDOW_TOP, 16'd0);
    add_write(drbb_pkg::CFG_WINDOW_BOTTOM, 16'd2047);
    add_write(drbb_pkg::CFG_WINDOW_LEFT, 16'd600);
    add_write(drbb_pkg::CFG_WINDOW_RIGHT, 16'd500);
    add_checked(128, 10, 550, 1, 0, NO_BOX, NO_BOX);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;

    foreach (stim_table[k]) begin
      step = stim_table[k];
      if (step.is_write) begin
        quiesce();
        write_reg(step.reg_index, step.reg_data);
      end else begin
        send_pixel(step.level, step.row, step.col, step.fend, step.typed_n,
                   step.want0, step.want1);
      end
    end

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 66; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 66; end
        default: begin send_idle_pct = 35; stall_pct = 35; end
      endcase
      for (int h = 0; h < 2; h++) begin
        quiesce();
        apply_setting(2 * p + h);
        target = pixels_sent + PHASE_PIXELS;
        while (pixels_sent < target) send_frame($urandom_range(1, 12));
      end
    end

    // Output held off for a long stretch while short frames keep coming,
    // so the block backs up and stalls its pixel input.
    quiesce();
    send_idle_pct = 0;
    stall_pct = 0;
    apply_setting(3);
    @(posedge clk);
    hold_start = 1'b1;
    repeat (40) send_frame(2);

    quiesce();
    $display("Covered %0d pixel words, %0d box words and %0d register writes over four",
             pixels_sent, boxes_checked, reg_writes);
    $display("idle/stall mixes, band/window/split extremes and one long output hold-off.");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
